>>> rtl/tsfm_pkg.sv
// ----------------------------------------------------------------------------
// tsfm_pkg: shared types and constants for the temperature fault monitor
// Holds the per-channel state record, result record, fault codes, register
// indexes and reset values of the configuration registers.
// ----------------------------------------------------------------------------
package tsfm_pkg;

    localparam int CHANNELS_DEF    = 4;
    localparam int HYST_TENTHS_DEF = 50;

    localparam int CH_W    = 2;
    localparam int VOLT_W  = 16;
    localparam int TEMP_W  = 13;
    localparam int TIME_W  = 32;
    localparam int SUST_W  = 16;
    localparam int NUM_CRIT = 4;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 8;

    localparam logic [CH_W-1:0] MOTOR_CH = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_EN   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LIM  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIM = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT_CH0  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT_CH3  = 4'd7;

    // reset values
    localparam logic [NUM_CRIT-1:0]     RST_CHAN_EN   = 4'd8;
    localparam logic [VOLT_W-1:0]       RST_OPEN_LIM  = 16'd3200;
    localparam logic [VOLT_W-1:0]       RST_SHORT_LIM = 16'd100;
    localparam logic [SUST_W-1:0]       RST_SUSTAIN   = 16'd500;
    localparam logic signed [TEMP_W-1:0] RST_CRIT_BOARD = 13'sd900;
    localparam logic signed [TEMP_W-1:0] RST_CRIT_MOTOR = 13'sd1500;

    typedef enum logic [2:0] {
        FAULT_NONE   = 3'd0,
        FAULT_OPEN   = 3'd1,
        FAULT_SHORT  = 3'd2,
        FAULT_INV_OT = 3'd3,
        FAULT_MOT_OT = 3'd4
    } t_fault;

    typedef struct packed {
        logic              oor_armed;
        logic              oor_latched;
        logic [TIME_W-1:0] oor_start;
        logic              ot_cond;
        logic              ot_raised;
        logic [TIME_W-1:0] ot_start;
    } t_chan_st;

    typedef struct packed {
        logic   oor;
        logic   ot;
        t_fault fault;
    } t_result;

    typedef struct packed {
        logic [VOLT_W-1:0] open_lim;
        logic [VOLT_W-1:0] short_lim;
        logic [SUST_W-1:0] sustain;
    } t_limits;

endpackage

>>> rtl/tsfm_eval.sv
// ----------------------------------------------------------------------------
// tsfm_eval: per-sample channel update
// Takes one registered sample and the current state of its channel, returns
// the channel's next state and the result word.
// ----------------------------------------------------------------------------
module tsfm_eval import tsfm_pkg::*; #(
    parameter int HYST_TENTHS = HYST_TENTHS_DEF
) (
    input  logic [CH_W-1:0]          i_channel,
    input  logic [VOLT_W-1:0]        i_voltage,
    input  logic signed [TEMP_W-1:0] i_temp,
    input  logic                     i_active,   // channel enabled and sample valid
    input  logic [TIME_W-1:0]        i_now,
    input  t_limits                  i_lim,
    input  logic signed [TEMP_W-1:0] i_crit,
    input  t_chan_st                 i_st,
    output t_chan_st                 o_st,
    output t_result                  o_res
);

    logic                       is_open;
    logic                       is_oor;
    logic [TIME_W-1:0]          oor_elapsed;
    logic [TIME_W-1:0]          ot_elapsed;
    logic [TIME_W-1:0]          sustain_ext;
    logic signed [TEMP_W:0]     temp_ext;
    logic signed [TEMP_W:0]     crit_ext;
    logic signed [TEMP_W:0]     crit_lo;
    t_chan_st                   st;
    t_fault                     fault;

    assign is_open     = i_voltage > i_lim.open_lim;
    assign is_oor      = is_open || (i_voltage < i_lim.short_lim);
    assign sustain_ext = {{(TIME_W-SUST_W){1'b0}}, i_lim.sustain};
    assign oor_elapsed = i_now - i_st.oor_start;
    assign temp_ext    = {i_temp[TEMP_W-1], i_temp};
    assign crit_ext    = {i_crit[TEMP_W-1], i_crit};
    assign crit_lo     = crit_ext - (TEMP_W+1)'(HYST_TENTHS);
    // start time used here is the updated one, so an onset compares at zero
    assign ot_elapsed  = i_now - st.ot_start;

    always_comb begin
        st    = i_st;
        fault = FAULT_NONE;
        if (!i_active) begin
            // timers kept, flags dropped
            st.oor_armed   = 1'b0;
            st.oor_latched = 1'b0;
            st.ot_cond     = 1'b0;
            st.ot_raised   = 1'b0;
        end else begin
            if (!is_oor) begin
                st.oor_armed   = 1'b0;
                st.oor_latched = 1'b0;
            end else if (!i_st.oor_armed) begin
                st.oor_armed   = 1'b1;
                st.oor_start   = i_now;
            end else if (oor_elapsed >= sustain_ext && !i_st.oor_latched) begin
                st.oor_latched = 1'b1;
                fault          = is_open ? FAULT_OPEN : FAULT_SHORT;
            end

            if (st.oor_latched) begin
                st.ot_cond   = 1'b0;
                st.ot_raised = 1'b0;
            end else begin
                if (i_st.ot_cond) begin
                    st.ot_cond = temp_ext > crit_lo;
                end else begin
                    st.ot_cond = temp_ext > crit_ext;
                    if (st.ot_cond) begin
                        st.ot_start = i_now;
                    end
                end
            end
        end
    end

    // second half kept apart so ot_elapsed sees the updated start time
    always_comb begin
        o_st  = st;
        o_res.fault = fault;
        if (i_active && !st.oor_latched) begin
            if (!st.ot_cond) begin
                o_st.ot_raised = 1'b0;
            end else if (ot_elapsed >= sustain_ext && !i_st.ot_raised) begin
                o_st.ot_raised = 1'b1;
                o_res.fault    = (i_channel == MOTOR_CH) ? FAULT_MOT_OT : FAULT_INV_OT;
            end
        end
        o_res.oor = i_active && st.oor_latched;
        o_res.ot  = i_active && st.ot_cond;
    end

endmodule

>>> rtl/temp_sensor_fault_monitor.sv
// ----------------------------------------------------------------------------
// temp_sensor_fault_monitor: sensor open/short and over-temperature monitor
// The sample word is captured in the input register, then its result word in the result register.
// Throughput: one sample per cycle unless the result side stalls; the channel state
// read-modify-write completes in the cycle between the input register and the result register.
// Reset (synchronous, active low) clears all channel state, empties both
// registers and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
module temp_sensor_fault_monitor import tsfm_pkg::*; #(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int HYST_TENTHS = HYST_TENTHS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [1:0] channel, [17:2] voltage_mv, [30:18] temperature, [62:31] now_ms
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] sample_valid
    input  logic                  s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] out_channel, [2] sensor_oor, [3] over_temp, [6:4] fault_code
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // a 2-bit channel field reaches at most four state entries
    localparam int NUM_ST = (CHANNELS < NUM_CRIT) ? CHANNELS : NUM_CRIT;
    localparam int IDX_W  = (NUM_ST > 1) ? $clog2(NUM_ST) : 1;

    // configuration
    logic [NUM_CRIT-1:0]      r_chan_en;
    t_limits                  r_lim;
    logic signed [TEMP_W-1:0] r_crit [NUM_CRIT];

    // input register
    logic                     r_in_vld;
    logic [CH_W-1:0]          r_in_chan;
    logic [VOLT_W-1:0]        r_in_volt;
    logic signed [TEMP_W-1:0] r_in_temp;
    logic                     r_in_sval;
    logic [TIME_W-1:0]        r_in_now;

    // result register
    logic                     r_out_vld;
    logic [CH_W-1:0]          r_out_chan;
    t_result                  r_out_res;

    t_chan_st                 r_st [NUM_ST];

    logic                     advance;
    logic                     in_range;
    logic [IDX_W-1:0]         st_idx;
    t_chan_st                 st_cur;
    t_chan_st                 st_next;
    t_result                  res;
    t_result                  n_out_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_en       <= RST_CHAN_EN;
            r_lim.open_lim  <= RST_OPEN_LIM;
            r_lim.short_lim <= RST_SHORT_LIM;
            r_lim.sustain   <= RST_SUSTAIN;
            for (int i = 0; i < NUM_CRIT; i++) begin
                r_crit[i] <= (i == int'(MOTOR_CH)) ? RST_CRIT_MOTOR : RST_CRIT_BOARD;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index) inside
                CFG_CHAN_EN:   r_chan_en       <= i_cfg_data[NUM_CRIT-1:0];
                CFG_OPEN_LIM:  r_lim.open_lim  <= i_cfg_data[VOLT_W-1:0];
                CFG_SHORT_LIM: r_lim.short_lim <= i_cfg_data[VOLT_W-1:0];
                CFG_SUSTAIN:   r_lim.sustain   <= i_cfg_data[SUST_W-1:0];
                [CFG_CRIT_CH0:CFG_CRIT_CH3]: begin
                    r_crit[i_cfg_index[1:0]] <= $signed(i_cfg_data[TEMP_W-1:0]);
                end
                default: ;
            endcase
        end
    end

    // the input register moves on whenever the result register is free or drains
    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_chan <= s_axis_tdata[1:0];
            r_in_volt <= s_axis_tdata[17:2];
            r_in_temp <= $signed(s_axis_tdata[30:18]);
            r_in_now  <= s_axis_tdata[62:31];
            r_in_sval <= s_axis_tuser;
        end
    end

    assign in_range = {{(32-CH_W){1'b0}}, r_in_chan} < 32'(CHANNELS);
    assign st_idx   = r_in_chan[IDX_W-1:0];
    assign st_cur   = in_range ? r_st[st_idx] : '0;

    tsfm_eval #(
        .HYST_TENTHS (HYST_TENTHS)
    ) u_eval (
        .i_channel (r_in_chan),
        .i_voltage (r_in_volt),
        .i_temp    (r_in_temp),
        .i_active  (r_chan_en[r_in_chan] && r_in_sval),
        .i_now     (r_in_now),
        .i_lim     (r_lim),
        .i_crit    (r_crit[r_in_chan]),
        .i_st      (st_cur),
        .o_st      (st_next),
        .o_res     (res)
    );

    assign n_out_res = in_range ? res : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ST; i++) begin
                r_st[i] <= '0;
            end
        end else if (advance && in_range) begin
            r_st[st_idx] <= st_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_chan <= r_in_chan;
            r_out_res  <= n_out_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out_res.fault, r_out_res.ot, r_out_res.oor, r_out_chan};

    // sensor faults always come with the latched flag
    a_sensor_fault_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_res.fault == FAULT_OPEN || r_out_res.fault == FAULT_SHORT))
        |-> r_out_res.oor)
        else $error("sensor fault without out-of-range flag");

    // over-temperature faults need the condition and no latched out-of-range
    a_ot_fault_cond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_res.fault == FAULT_INV_OT || r_out_res.fault == FAULT_MOT_OT))
        |-> (r_out_res.ot && !r_out_res.oor))
        else $error("over-temperature fault without condition");

    // input side stalls only while a result is held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !s_axis_tready) |-> (r_out_vld && !m_axis_tready))
        else $error("input stalled with result register free");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && !r_in_vld))
        else $error("pipeline not empty after reset");

endmodule

>>> dv/tb_temp_sensor_fault_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_temp_sensor_fault_monitor: self-checking bench for the fault monitor
// Drives sample words and register writes, predicts the per-channel
// out-of-range / over-temperature status in a tracker object and compares
// every result word with the oldest prediction, under random stalls.
// ----------------------------------------------------------------------------
module tb_temp_sensor_fault_monitor;
    import tsfm_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    temp_sensor_fault_monitor DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    class fault_status_tracker;
        typedef struct {
            bit [1:0] ch;
            bit       oor;
            bit       ot;
            t_fault   fault;
        } t_status;

        bit [3:0]                chan_en;
        bit [VOLT_W-1:0]         open_lim;
        bit [VOLT_W-1:0]         short_lim;
        bit [SUST_W-1:0]         sustain;
        logic signed [TEMP_W-1:0] crit [NUM_CRIT];

        bit              oor_pend   [CHANNELS_DEF];
        bit              oor_lat    [CHANNELS_DEF];
        bit [TIME_W-1:0] oor_t0     [CHANNELS_DEF];
        bit              ot_cond    [CHANNELS_DEF];
        bit              ot_rais    [CHANNELS_DEF];
        bit [TIME_W-1:0] ot_t0      [CHANNELS_DEF];

        t_status pending_status [$];
        int      errors;

        function new();
            chan_en   = RST_CHAN_EN;
            open_lim  = RST_OPEN_LIM;
            short_lim = RST_SHORT_LIM;
            sustain   = RST_SUSTAIN;
            crit[0]   = RST_CRIT_BOARD;
            crit[1]   = RST_CRIT_BOARD;
            crit[2]   = RST_CRIT_BOARD;
            crit[3]   = RST_CRIT_MOTOR;
            for (int c = 0; c < CHANNELS_DEF; c++) begin
                oor_pend[c] = 0;
                oor_lat[c]  = 0;
                oor_t0[c]   = '0;
                ot_cond[c]  = 0;
                ot_rais[c]  = 0;
                ot_t0[c]    = '0;
            end
            errors = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_CHAN_EN:   chan_en   = d[3:0];
                CFG_OPEN_LIM:  open_lim  = d;
                CFG_SHORT_LIM: short_lim = d;
                CFG_SUSTAIN:   sustain   = d;
                CFG_CRIT_CH0, CFG_CRIT_CH0 + 4'd1, CFG_CRIT_CH0 + 4'd2, CFG_CRIT_CH3:
                    crit[idx[1:0]] = d[TEMP_W-1:0];
                default: ;  // unused index, no effect
            endcase
        endfunction

        // predict the status word for one accepted sample
        function void track_sample(bit [1:0] ch, bit [VOLT_W-1:0] v,
                                   logic signed [TEMP_W-1:0] t, bit ok,
                                   bit [TIME_W-1:0] ts);
            t_status         s;
            bit              is_open;
            bit              is_oor;
            bit [TIME_W-1:0] elapsed;
            s.ch    = ch;
            s.oor   = 0;
            s.ot    = 0;
            s.fault = FAULT_NONE;
            if (!chan_en[ch] || !ok) begin
                // start times are kept on purpose
                oor_pend[ch] = 0;
                oor_lat[ch]  = 0;
                ot_cond[ch]  = 0;
                ot_rais[ch]  = 0;
                pending_status.push_back(s);
                return;
            end
            is_open = v > open_lim;
            is_oor  = is_open || (v < short_lim);
            if (!is_oor) begin
                oor_pend[ch] = 0;
                oor_lat[ch]  = 0;
            end else if (!oor_pend[ch]) begin
                oor_pend[ch] = 1;
                oor_t0[ch]   = ts;
            end else begin
                elapsed = ts - oor_t0[ch];
                if (elapsed >= {16'd0, sustain} && !oor_lat[ch]) begin
                    oor_lat[ch] = 1;
                    s.fault     = is_open ? FAULT_OPEN : FAULT_SHORT;
                end
            end
            if (oor_lat[ch]) begin
                ot_cond[ch] = 0;
                ot_rais[ch] = 0;
            end else begin
                if (ot_cond[ch]) begin
                    ot_cond[ch] = int'(t) > int'(crit[ch]) - HYST_TENTHS_DEF;
                end else begin
                    ot_cond[ch] = int'(t) > int'(crit[ch]);
                    if (ot_cond[ch]) ot_t0[ch] = ts;
                end
                elapsed = ts - ot_t0[ch];
                if (!ot_cond[ch]) begin
                    ot_rais[ch] = 0;
                end else if (elapsed >= {16'd0, sustain} && !ot_rais[ch]) begin
                    ot_rais[ch] = 1;
                    s.fault     = (ch == MOTOR_CH) ? FAULT_MOT_OT : FAULT_INV_OT;
                end
            end
            s.oor = oor_lat[ch];
            s.ot  = ot_cond[ch];
            pending_status.push_back(s);
        endfunction

        function void check_status(logic [OUT_DATA_W-1:0] w);
            t_status exp_s;
            if (pending_status.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result word %h", w);
                return;
            end
            exp_s = pending_status.pop_front();
            if (w[1:0] !== exp_s.ch || w[2] !== exp_s.oor || w[3] !== exp_s.ot ||
                w[6:4] !== exp_s.fault) begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: ch exp %0d got %0d, oor exp %0b got %0b, ",
                              "ot exp %0b got %0b, fault exp %0d got %0d"},
                             exp_s.ch, w[1:0], exp_s.oor, w[2], exp_s.ot, w[3],
                             exp_s.fault, w[6:4]);
            end
        endfunction
    endclass

    fault_status_tracker sb = new();

    bit [TIME_W-1:0] now_ms;
    int              v_mode [CHANNELS_DEF];
    int              t_mode [CHANNELS_DEF];
    int              burst_left = 0;
    int              rdy_hold   = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // result side backpressure: mostly short stalls, a few long ones, some clear runs
    always @(posedge i_clk) begin
        int r;
        if (rdy_hold > 0) begin
            rdy_hold <= rdy_hold - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                m_axis_tready <= 1'b1;
                rdy_hold      <= $urandom_range(50, 150);
            end else if (r < 60) begin
                m_axis_tready <= 1'b1;
                rdy_hold      <= $urandom_range(0, 4);
            end else if (r < 92) begin
                m_axis_tready <= 1'b0;
                rdy_hold      <= $urandom_range(0, 3);
            end else begin
                m_axis_tready <= 1'b0;
                rdy_hold      <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_status(m_axis_tdata);
    end

    function automatic int next_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_sample(input bit [1:0] ch, input bit [VOLT_W-1:0] v,
                               input logic signed [TEMP_W-1:0] t, input bit ok,
                               input bit [TIME_W-1:0] ts);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, ts, t, v, ch};
        s_axis_tuser  <= ok;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.track_sample(ch, v, t, ok, ts);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.apply_reg(idx, d);
    endtask

    task automatic set_config(input bit [3:0] en, input bit [15:0] open_mv,
                              input bit [15:0] short_mv, input bit [15:0] sus,
                              input int c0, input int c1, input int c2, input int c3);
        write_reg(CFG_CRIT_CH3 + 4'd1 + 4'($urandom_range(0, 7)), 16'($urandom));
        write_reg(CFG_CHAN_EN, {12'd0, en});
        write_reg(CFG_OPEN_LIM, open_mv);
        write_reg(CFG_SHORT_LIM, short_mv);
        write_reg(CFG_SUSTAIN, sus);
        write_reg(CFG_CRIT_CH0, 16'(c0));
        write_reg(CFG_CRIT_CH0 + 4'd1, 16'(c1));
        write_reg(CFG_CRIT_CH0 + 4'd2, 16'(c2));
        write_reg(CFG_CRIT_CH3, 16'(c3));
        i_cfg_valid <= 1'b0;
    endtask

    // one result per sample: a short pause after the last word
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_status.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic bit [VOLT_W-1:0] pick_voltage(int mode);
        bit [VOLT_W-1:0] v;
        case (mode)
            0: v = (sb.short_lim <= sb.open_lim) ?
                   16'($urandom_range(sb.open_lim, sb.short_lim)) : 16'($urandom);
            1: v = (sb.open_lim < 16'hFFFF) ?
                   16'($urandom_range(16'hFFFF, sb.open_lim + 1)) : 16'hFFFF;
            2: v = (sb.short_lim > 0) ? 16'($urandom_range(sb.short_lim - 1, 0)) : 16'd0;
            default: begin
                case ($urandom_range(0, 4))
                    0: v = sb.open_lim;
                    1: v = sb.open_lim + 16'd1;
                    2: v = sb.short_lim;
                    3: v = sb.short_lim - 16'd1;
                    default: v = 16'($urandom);
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic signed [TEMP_W-1:0] pick_temp(int ch, int mode);
        int c;
        int r;
        int tv;
        c = int'(sb.crit[ch]);
        case (mode)
            0: begin
                r  = $urandom_range(60, 600);
                tv = c - r;
            end
            1: begin
                r  = $urandom_range(1, 300);
                tv = c + r;
            end
            2: begin
                // straddle the hysteresis band edges
                r  = $urandom_range(0, 60);
                tv = c - 55 + r;
            end
            default: begin
                r  = $urandom_range(0, 5000);
                tv = r - 2000;
            end
        endcase
        if (tv < -2000) tv = -2000;
        if (tv > 3000)  tv = 3000;
        return tv[TEMP_W-1:0];
    endfunction

    task automatic run_random(input int n, input bit [TIME_W-1:0] start_ms);
        bit [1:0] ch;
        bit       ok;
        ch     = 2'd0;
        now_ms = start_ms;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 0) ch = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0) v_mode[ch] = $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0) t_mode[ch] = $urandom_range(0, 3);
            if ($urandom_range(0, 49) == 0)
                now_ms = $urandom;
            else
                now_ms = now_ms + $urandom_range(0, sb.sustain / 3 + 3);
            ok = ($urandom_range(0, 24) != 0);
            send_sample(ch, pick_voltage(v_mode[ch]), pick_temp(ch, t_mode[ch]), ok, now_ms);
        end
        drain();
    endtask

    initial begin
        for (int c = 0; c < CHANNELS_DEF; c++) begin
            v_mode[c] = 0;
            t_mode[c] = 0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: only the motor channel is enabled, sustain 500 ms
        send_sample(2'd3, 16'd1500, 13'sd250, 1'b1, 32'd1000);
        send_sample(2'd0, 16'hFFFF, 13'sd3000, 1'b1, 32'd1000);
        send_sample(2'd3, 16'hFFFF, -13'sd2000, 1'b1, 32'd1000);
        send_sample(2'd3, 16'hFFFF, 13'sd0, 1'b1, 32'd1499);
        send_sample(2'd3, 16'hFFFF, 13'sd0, 1'b1, 32'd1500);
        send_sample(2'd3, 16'd0, 13'sd0, 1'b1, 32'd1600);
        send_sample(2'd3, 16'd1500, 13'sd1501, 1'b1, 32'd1700);
        send_sample(2'd3, 16'd1500, 13'sd1451, 1'b1, 32'd2200);
        send_sample(2'd3, 16'd1500, 13'sd1450, 1'b1, 32'd2300);
        send_sample(2'd3, 16'd1500, 13'sd1600, 1'b0, 32'd2400);
        drain();

        // zero sustain: first out-of-range word only arms, onset faults at once
        set_config(4'hF, 16'd3200, 16'd100, 16'd0, 900, 900, 900, 1500);
        send_sample(2'd0, 16'd3201, 13'sd0, 1'b1, 32'd0);
        send_sample(2'd0, 16'd3201, 13'sd0, 1'b1, 32'd0);
        send_sample(2'd1, 16'd99, 13'sd0, 1'b1, 32'd5);
        send_sample(2'd1, 16'd99, 13'sd0, 1'b1, 32'd5);
        send_sample(2'd2, 16'd3200, 13'sd901, 1'b1, 32'd10);
        send_sample(2'd2, 16'd100, 13'sd851, 1'b1, 32'd11);
        send_sample(2'd2, 16'hFFFF, 13'sd2000, 1'b1, 32'd12);
        send_sample(2'd2, 16'hFFFF, 13'sd2000, 1'b1, 32'd13);
        send_sample(2'd3, 16'd1000, 13'sd1501, 1'b1, 32'hFFFF_FFFF);
        send_sample(2'd3, 16'd1000, 13'sd1501, 1'b0, 32'd3);
        send_sample(2'd0, 16'd1000, -13'sd2000, 1'b1, 32'd20);
        send_sample(2'd1, 16'd1000, 13'sd3000, 1'b1, 32'd21);
        drain();

        // timestamps wrap early in this phase
        set_config(4'hF, 16'd3200, 16'd100, 16'd200, -400, 3000, 0, 1500);
        run_random(130, 32'hFFFF_FF00);
        set_config(4'hA, 16'hFFFF, 16'd0, 16'hFFFF, 3000, -400, 900, 3000);
        run_random(110, $urandom);
        // every voltage is out of range here
        set_config(4'hF, 16'd0, 16'hFFFF, 16'd30, 900, 900, 900, 1500);
        run_random(90, $urandom);
        set_config(4'h0, 16'd3200, 16'd100, 16'd500, 900, 900, 900, 1500);
        run_random(40, $urandom);
        for (int p = 0; p < 3; p++) begin
            set_config(4'($urandom_range(1, 15)), 16'($urandom_range(2000, 4000)),
                       16'($urandom_range(0, 600)),
                       ($urandom_range(0, 9) < 3) ? 16'd0 : 16'($urandom_range(1, 800)),
                       int'($urandom_range(0, 3400)) - 400,
                       int'($urandom_range(0, 3400)) - 400,
                       int'($urandom_range(0, 3400)) - 400,
                       int'($urandom_range(0, 3400)) - 400);
            run_random(130, $urandom);
        end

        drain();
        if (sb.errors == 0 && sb.pending_status.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
